### rtl/core/ttdw_pkg.sv
// Shared types, constants and the arctangent table of the waypoint controller.
package ttdw_pkg;

  // Number of vectoring iterations; the table below supports 8 to 24.
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ITER_W       = 5;
  localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_STEPS - 1);

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DELTA_W = 17;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned POWER_W = 15;
  localparam int unsigned ANGLE_W = 16;

  // Square root operand: (dx*dx + dy*dy) * 256 needs 42 bits, the root 21.
  localparam int unsigned SUMSQ_W = 34;
  localparam int unsigned RAD_W   = 42;
  localparam int unsigned ROOT_W  = 21;
  localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(ROOT_W - 1);

  // CORDIC vector and angle widths; the angle is kept modulo one turn.
  localparam int unsigned VEC_W = 28;
  localparam int unsigned ZACC_W = 24;
  localparam logic [ZACC_W-1:0] HALF_TURN_Z = 24'h800000;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = 21;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [ANGLE_W-1:0] ANGLE_UP   = 16'd16384;
  localparam logic [ANGLE_W-1:0] ANGLE_DOWN = 16'd49152;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DIST_SCALE  = 2'd0;
  localparam logic [1:0] CFG_TURN_SCALE  = 2'd1;
  localparam logic [1:0] CFG_DRIVE_POWER = 2'd2;

  // Item kinds carried in tuser.
  localparam logic ACT_GOTO = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    MODE_STOP    = 2'd0,
    MODE_TURN    = 2'd1,
    MODE_FORWARD = 2'd2
  } mode_e;

  typedef enum logic [6:0] {
    SEQ_IDLE = 7'b0000001,
    SEQ_SQX  = 7'b0000010,
    SEQ_SQY  = 7'b0000100,
    SEQ_SUM  = 7'b0001000,
    SEQ_WAIT = 7'b0010000,
    SEQ_MULD = 7'b0100000,
    SEQ_MULT = 7'b1000000
  } seq_e;

  // Start/done pair between the sequencer and an iterative unit.
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

  // atan(2^-i) in 2^-24 turns.
  function automatic logic [ZACC_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic [ZACC_W-1:0] val;
    case (idx)
      5'd0:    val = 24'd2097152;
      5'd1:    val = 24'd1238021;
      5'd2:    val = 24'd654136;
      5'd3:    val = 24'd332050;
      5'd4:    val = 24'd166669;
      5'd5:    val = 24'd83416;
      5'd6:    val = 24'd41718;
      5'd7:    val = 24'd20860;
      5'd8:    val = 24'd10430;
      5'd9:    val = 24'd5215;
      5'd10:   val = 24'd2608;
      5'd11:   val = 24'd1304;
      5'd12:   val = 24'd652;
      5'd13:   val = 24'd326;
      5'd14:   val = 24'd163;
      5'd15:   val = 24'd81;
      5'd16:   val = 24'd41;
      5'd17:   val = 24'd20;
      5'd18:   val = 24'd10;
      5'd19:   val = 24'd5;
      5'd20:   val = 24'd3;
      5'd21:   val = 24'd1;
      5'd22:   val = 24'd1;
      default: val = 24'd0;
    endcase
    return val;
  endfunction

endpackage

### rtl/core/ttdw_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module ttdw_isqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ttdw_pkg::RAD_W-1:0]       rad_i,
  output logic                             done_o,
  output logic [ttdw_pkg::ROOT_W-1:0]      root_o
);

  logic                            busy_q, busy_d;
  logic [ttdw_pkg::ITER_W-1:0]     cnt_q, cnt_d;
  logic [ttdw_pkg::RAD_W-1:0]      rad_q, rad_d;
  logic [ttdw_pkg::ROOT_W+2:0]     rem_q, rem_d;
  logic [ttdw_pkg::ROOT_W-1:0]     root_q, root_d;
  logic [ttdw_pkg::ROOT_W+2:0]     rem_sh;
  logic [ttdw_pkg::ROOT_W+2:0]     trial;

  assign rem_sh = {rem_q[ttdw_pkg::ROOT_W:0], rad_q[ttdw_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[ttdw_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ttdw_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ttdw_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ttdw_pkg::ROOT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = ~busy_q;
  assign root_o = root_q;

endmodule

### rtl/core/ttdw_cordic.sv
// Iterative CORDIC vectoring unit that yields the bearing in 2^-24 turns.
module ttdw_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ttdw_pkg::DELTA_W-1:0] dx_i,
  input  logic signed [ttdw_pkg::DELTA_W-1:0] dy_i,
  output logic                               done_o,
  output logic [ttdw_pkg::ZACC_W-1:0]        z_o
);

  logic                               busy_q, busy_d;
  logic [ttdw_pkg::ITER_W-1:0]        cnt_q, cnt_d;
  logic signed [ttdw_pkg::VEC_W-1:0]  x_q, x_d, y_q, y_d;
  logic [ttdw_pkg::ZACC_W-1:0]        z_q, z_d;
  logic signed [ttdw_pkg::VEC_W-1:0]  x_sh, y_sh;
  logic signed [ttdw_pkg::DELTA_W-1:0] dx_abs, dy_adj;
  logic [ttdw_pkg::ZACC_W-1:0]        atan_val;

  assign x_sh     = x_q >>> cnt_q;
  assign y_sh     = y_q >>> cnt_q;
  assign atan_val = ttdw_pkg::atan_lut(cnt_q);

  // A target behind the robot is pre-rotated by half a turn.
  assign dx_abs = dx_i[ttdw_pkg::DELTA_W-1] ? -dx_i : dx_i;
  assign dy_adj = dx_i[ttdw_pkg::DELTA_W-1] ? -dy_i : dy_i;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = {{(ttdw_pkg::VEC_W-ttdw_pkg::DELTA_W-8){dx_abs[ttdw_pkg::DELTA_W-1]}},
                dx_abs, 8'h00};
      y_d    = {{(ttdw_pkg::VEC_W-ttdw_pkg::DELTA_W-8){dy_adj[ttdw_pkg::DELTA_W-1]}},
                dy_adj, 8'h00};
      z_d    = dx_i[ttdw_pkg::DELTA_W-1] ? ttdw_pkg::HALF_TURN_Z : '0;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + atan_val;
      end else begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - atan_val;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ttdw_pkg::CORDIC_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = ~busy_q;
  assign z_o    = z_q;

endmodule

### rtl/core/turn_then_drive_waypoint_controller_unit.sv
// Top level of the turn-then-drive waypoint controller: sequencer, shared multiplier, mode.
//
//  channel  | direction | handshake                     | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata 128 b, tuser 1 b (kind)
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata 40 b
//  cfg      | in        | cfg_we_i (no wait)            | cfg_idx_i 2 b, cfg_data_i 16 b
//
// A tick item leaves the sequencer in IDLE, and a new item may follow once the result register is free.
// A goto item runs three multiplier passes for the squared distance, then the
// bit-serial square root (the CORDIC runs alongside it), two scaling multiplies
// and the result. The square root, not the CORDIC, sets how long the item waits.
// After reset the mode is STOP and the registers hold their documented values.
// The input is not ready while a goto item is at work or while the result
// register is full and not being taken.
module turn_then_drive_waypoint_controller_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // target_x, target_y, current_x, current_y, current_heading, turned_steps,
  // travelled_steps
  input  logic [127:0]                       s_axis_tdata,
  // action
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // left_power, right_power, power_write, motors_off, clear_odometry, finished,
  // turn_right, 3 bits zero
  output logic [39:0]                        m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [ttdw_pkg::SCALE_W-1:0]       cfg_data_i
);

  // Configuration registers.
  logic [ttdw_pkg::SCALE_W-1:0] dist_scale_q, turn_scale_q;
  logic [ttdw_pkg::POWER_W-1:0] drive_power_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_scale_q  <= 16'd256;
      turn_scale_q  <= 16'd256;
      drive_power_q <= 15'd2500;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttdw_pkg::CFG_DIST_SCALE:  dist_scale_q  <= cfg_data_i;
        ttdw_pkg::CFG_TURN_SCALE:  turn_scale_q  <= cfg_data_i;
        ttdw_pkg::CFG_DRIVE_POWER: drive_power_q <= cfg_data_i[ttdw_pkg::POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic signed [ttdw_pkg::COORD_W-1:0] tgt_x, tgt_y, cur_x, cur_y;
  logic [ttdw_pkg::ANGLE_W-1:0]        cur_head;
  logic [ttdw_pkg::STEP_W-1:0]         turned, travelled;
  logic signed [ttdw_pkg::DELTA_W-1:0] dx_in, dy_in;

  assign tgt_x     = s_axis_tdata[15:0];
  assign tgt_y     = s_axis_tdata[31:16];
  assign cur_x     = s_axis_tdata[47:32];
  assign cur_y     = s_axis_tdata[63:48];
  assign cur_head  = s_axis_tdata[79:64];
  assign turned    = s_axis_tdata[103:80];
  assign travelled = s_axis_tdata[127:104];
  assign dx_in = ttdw_pkg::DELTA_W'(tgt_x) - ttdw_pkg::DELTA_W'(cur_x);
  assign dy_in = ttdw_pkg::DELTA_W'(tgt_y) - ttdw_pkg::DELTA_W'(cur_y);

  ttdw_pkg::seq_e  seq_q, seq_d;
  ttdw_pkg::mode_e mode_q;
  logic [ttdw_pkg::STEP_W-1:0] turn_tgt_q, dist_tgt_q;
  logic                        rot_right_q;

  logic                        out_valid_q;
  logic signed [15:0]          out_left_q, out_right_q;
  logic                        out_pw_q, out_off_q, out_clr_q, out_fin_q, out_tr_q;

  logic in_acc, out_free, goto_acc, tick_acc, goto_done;

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = (seq_q == ttdw_pkg::SEQ_IDLE) & out_free;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign goto_acc      = in_acc & (s_axis_tuser[0] == ttdw_pkg::ACT_GOTO);
  assign tick_acc      = in_acc & (s_axis_tuser[0] == ttdw_pkg::ACT_TICK);

  // Goto operands held while the item is at work.
  logic signed [ttdw_pkg::DELTA_W-1:0] dx_q, dy_q;
  logic [ttdw_pkg::ANGLE_W-1:0]        head_q;
  logic [15:0]                         dy_abs;

  always_ff @(posedge clk_i) begin
    if (goto_acc) begin
      dx_q   <= dx_in;
      dy_q   <= dy_in;
      head_q <= cur_head;
    end
  end

  assign dy_abs = 16'(dy_q[ttdw_pkg::DELTA_W-1] ? -dy_q : dy_q);

  // Iterative units.
  ttdw_pkg::unit_ctl_t root_ctl, cord_ctl;
  logic [ttdw_pkg::ROOT_W-1:0]  root;
  logic [ttdw_pkg::ZACC_W-1:0]  zacc;
  logic [ttdw_pkg::SUMSQ_W-1:0] acc_q;
  logic [ttdw_pkg::PROD_W-1:0]  prod_q;
  logic [ttdw_pkg::SUMSQ_W-1:0] sumsq;

  assign sumsq          = acc_q + ttdw_pkg::SUMSQ_W'(prod_q);
  assign root_ctl.start = (seq_q == ttdw_pkg::SEQ_SUM);
  assign cord_ctl.start = goto_acc;

  ttdw_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_ctl.start),
    .rad_i   ({sumsq, 8'h00}),
    .done_o  (root_ctl.done),
    .root_o  (root)
  );

  ttdw_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_ctl.start),
    .dx_i    (dx_in),
    .dy_i    (dy_in),
    .done_o  (cord_ctl.done),
    .z_o     (zacc)
  );

  // Bearing rounded to 2^-16 turn, heading error and its magnitude.
  logic [ttdw_pkg::ZACC_W-1:0]  z_round;
  logic [ttdw_pkg::ANGLE_W-1:0] bear, head_err, err_mag;
  logic [ttdw_pkg::ANGLE_W-1:0] mag_q;
  logic                         dir_q;

  assign z_round  = zacc + 24'd128;
  assign bear     = (dx_q == '0) ? ((dy_q > 0) ? ttdw_pkg::ANGLE_UP : ttdw_pkg::ANGLE_DOWN)
                                 : z_round[ttdw_pkg::ZACC_W-1 -: ttdw_pkg::ANGLE_W];
  assign head_err = head_q - bear;
  assign err_mag  = head_err[ttdw_pkg::ANGLE_W-1] ? -head_err : head_err;

  // Shared multiplier, one product per cycle, but the turn product is held in MULT until the result is written.
  logic [ttdw_pkg::MUL_A_W-1:0] mul_a;
  logic [ttdw_pkg::MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (seq_q)
      ttdw_pkg::SEQ_IDLE: begin
        mul_a = ttdw_pkg::MUL_A_W'(dx_in[ttdw_pkg::DELTA_W-1] ? -dx_in : dx_in);
        mul_b = 16'(dx_in[ttdw_pkg::DELTA_W-1] ? -dx_in : dx_in);
      end
      // The y square is held through SQY so that SUM sees it beside the x square.
      ttdw_pkg::SEQ_SQX, ttdw_pkg::SEQ_SQY: begin
        mul_a = ttdw_pkg::MUL_A_W'(dy_abs);
        mul_b = dy_abs;
      end
      ttdw_pkg::SEQ_MULD: begin
        mul_a = root;
        mul_b = dist_scale_q;
      end
      ttdw_pkg::SEQ_MULT: begin
        mul_a = ttdw_pkg::MUL_A_W'(mag_q);
        mul_b = turn_scale_q;
      end
      default: ;
    endcase
  end

  logic [ttdw_pkg::STEP_W-1:0] dist_q;
  logic [ttdw_pkg::STEP_W-1:0] turn_sat;
  logic goto_ready;

  // Distance product shifted by 16 has at most 21 bits and never saturates.
  assign turn_sat = (|prod_q[ttdw_pkg::PROD_W-1:ttdw_pkg::STEP_W+8])
                    ? {ttdw_pkg::STEP_W{1'b1}} : prod_q[ttdw_pkg::STEP_W+7:8];
  assign goto_ready = root_ctl.done & cord_ctl.done;

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      ttdw_pkg::SEQ_IDLE: if (goto_acc) seq_d = ttdw_pkg::SEQ_SQX;
      ttdw_pkg::SEQ_SQX:  seq_d = ttdw_pkg::SEQ_SQY;
      ttdw_pkg::SEQ_SQY:  seq_d = ttdw_pkg::SEQ_SUM;
      ttdw_pkg::SEQ_SUM:  seq_d = ttdw_pkg::SEQ_WAIT;
      ttdw_pkg::SEQ_WAIT: if (goto_ready) seq_d = ttdw_pkg::SEQ_MULD;
      ttdw_pkg::SEQ_MULD: seq_d = ttdw_pkg::SEQ_MULT;
      ttdw_pkg::SEQ_MULT: if (out_free) seq_d = ttdw_pkg::SEQ_IDLE;
      default:            seq_d = ttdw_pkg::SEQ_IDLE;
    endcase
  end

  assign goto_done = (seq_q == ttdw_pkg::SEQ_MULT) & out_free;

  // In MULT the product register first holds the distance product; the turn
  // product lands in the next cycle and is held until the end of the item.
  logic turn_pend_q;

  always_ff @(posedge clk_i) begin
    if (seq_q != ttdw_pkg::SEQ_MULT || !turn_pend_q) begin
      prod_q <= mul_a * mul_b;
    end
    if (seq_q == ttdw_pkg::SEQ_SQX) begin
      acc_q <= ttdw_pkg::SUMSQ_W'(prod_q);
    end
    if (seq_q == ttdw_pkg::SEQ_WAIT && goto_ready) begin
      mag_q <= err_mag;
      dir_q <= ~head_err[ttdw_pkg::ANGLE_W-1];
    end
    if (seq_q == ttdw_pkg::SEQ_MULT && !turn_pend_q) begin
      dist_q <= ttdw_pkg::STEP_W'(prod_q[ttdw_pkg::PROD_W-1:16]);
    end
  end

  // The MULT state captures the turn product before it can finish.
  logic goto_fin;
  assign goto_fin = goto_done & turn_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_pend_q <= 1'b0;
    end else begin
      turn_pend_q <= (seq_q == ttdw_pkg::SEQ_MULT) & ~goto_fin;
    end
  end

  ttdw_pkg::seq_e seq_n;
  assign seq_n = (seq_q == ttdw_pkg::SEQ_MULT && !goto_fin) ? ttdw_pkg::SEQ_MULT : seq_d;

  // Tick decision.
  logic signed [15:0] pwr_pos, pwr_neg;
  logic signed [15:0] t_left, t_right;
  logic               t_pw, t_off;
  ttdw_pkg::mode_e    t_mode;

  assign pwr_pos = {1'b0, drive_power_q};
  assign pwr_neg = -pwr_pos;

  always_comb begin
    t_left  = '0;
    t_right = '0;
    t_pw    = 1'b0;
    t_off   = 1'b0;
    t_mode  = mode_q;
    unique case (mode_q)
      ttdw_pkg::MODE_TURN: begin
        if (turned < turn_tgt_q) begin
          t_pw    = 1'b1;
          t_left  = rot_right_q ? pwr_pos : pwr_neg;
          t_right = rot_right_q ? pwr_neg : pwr_pos;
        end else begin
          t_mode = ttdw_pkg::MODE_FORWARD;
        end
      end
      ttdw_pkg::MODE_FORWARD: begin
        if (travelled < dist_tgt_q) begin
          t_pw    = 1'b1;
          t_left  = pwr_pos;
          t_right = pwr_pos;
        end else begin
          t_off  = 1'b1;
          t_mode = ttdw_pkg::MODE_STOP;
        end
      end
      default: begin
        t_off  = 1'b1;
        t_mode = ttdw_pkg::MODE_STOP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= ttdw_pkg::SEQ_IDLE;
      mode_q      <= ttdw_pkg::MODE_STOP;
      turn_tgt_q  <= '0;
      dist_tgt_q  <= '0;
      rot_right_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      seq_q <= seq_n;
      if (tick_acc) begin
        mode_q      <= t_mode;
        out_valid_q <= 1'b1;
      end else if (goto_fin) begin
        mode_q      <= ttdw_pkg::MODE_TURN;
        turn_tgt_q  <= turn_sat;
        dist_tgt_q  <= dist_q;
        rot_right_q <= dir_q;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      out_left_q  <= t_left;
      out_right_q <= t_right;
      out_pw_q    <= t_pw;
      out_off_q   <= t_off;
      out_clr_q   <= 1'b0;
      out_fin_q   <= (t_mode == ttdw_pkg::MODE_STOP);
      out_tr_q    <= rot_right_q;
    end else if (goto_fin) begin
      out_left_q  <= '0;
      out_right_q <= '0;
      out_pw_q    <= 1'b0;
      out_off_q   <= 1'b0;
      out_clr_q   <= 1'b1;
      out_fin_q   <= 1'b0;
      out_tr_q    <= dir_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_tr_q, out_fin_q, out_clr_q, out_off_q, out_pw_q,
                          out_right_q, out_left_q};

endmodule

### rtl/core/ttdw_checker.sv
// Port-level checks of the waypoint controller and their bind to the top level.
module ttdw_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [0:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [39:0]  m_axis_tdata
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // A goto result clears odometry and never drives the motors or reports STOP.
  a_goto_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34] |->
      !m_axis_tdata[32] && !m_axis_tdata[33] && !m_axis_tdata[35] &&
      m_axis_tdata[31:0] == 32'h0)
    else $error("goto result carries a motor command");

  // Driving and switching off never come together.
  a_pw_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]))
    else $error("power write together with motors off");

  // A turn command drives the wheels in opposite directions.
  a_turn_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] && m_axis_tdata[15:0] != m_axis_tdata[31:16] |->
      m_axis_tdata[15:0] == 16'(-m_axis_tdata[31:16]))
    else $error("unequal powers that are not a turn");

  // A goto item keeps the input closed in the next cycle while it is worked on.
  a_goto_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == 1'b0 |=> !s_axis_tready)
    else $error("input ready while a goto item is at work");

endmodule

bind turn_then_drive_waypoint_controller_unit ttdw_checker u_ttdw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
